### src/pcrq_pkg.sv
// ----------------------------------------------------------------------------
// pcrq_pkg
// Shared types and constants of the pointwise convolution requant unit.
// ----------------------------------------------------------------------------
package pcrq_pkg;

  localparam int unsigned OUT_MAX   = 32767;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned SHIFT_MAX = 71;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_PARAM  = 2'd1,
    OP_PIXEL  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_SHIFT = 1'b0,
    REG_NONE  = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [12:0]        target_index;
    logic [63:0]        lanes_0_3;
    logic [63:0]        lanes_4_7;
    logic [63:0]        lanes_8_11;
    logic [63:0]        lanes_12_15;
    logic [63:0]        lanes_16_19;
    logic [63:0]        lanes_20_23;
    logic [63:0]        lanes_24_27;
    logic [63:0]        lanes_28_31;
    logic signed [31:0] channel_multiplier;
    logic signed [31:0] channel_bias;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  word_number;
    logic [62:0] out_0_3;
    logic [62:0] out_4_7;
    logic [62:0] out_8_11;
    logic [62:0] out_12_15;
    logic [62:0] out_16_19;
    logic [62:0] out_20_23;
    logic [62:0] out_24_27;
    logic [62:0] out_28_31;
    logic        last_word;
  } out_item_t;

  // token walking down the mac chain, sized for the largest configuration
  typedef struct packed {
    logic               vld;
    logic               first;
    logic               last;
    logic [7:0]         wd;
    logic [7:0]         grp;
    logic [4:0]         lane;
    logic signed [15:0] pix;
  } mac_tok_t;

  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] acc;
  } res_tok_t;

endpackage

### src/pcrq_ram.sv
// ----------------------------------------------------------------------------
// pcrq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pcrq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/pcrq_mac_cell.sv
// ----------------------------------------------------------------------------
// pcrq_mac_cell
// One output lane: own weight bank, one multiply-accumulate per cycle,
// forwards the pixel token and shifts finished sums toward cell 0.
// ----------------------------------------------------------------------------
module pcrq_mac_cell
  import pcrq_pkg::*;
#(
  parameter int unsigned LANES = 32,
  parameter int unsigned WPP   = 16,
  localparam int unsigned RW = (WPP * WPP > 1) ? $clog2(WPP * WPP) : 1,
  localparam int unsigned LW = $clog2(LANES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mac_tok_t             tok_i,
  output mac_tok_t             tok_o,
  input  res_tok_t             res_i,
  output res_tok_t             res_o,
  input  logic                 wr_en_i,
  input  logic [RW-1:0]        wr_row_i,
  input  logic [16*LANES-1:0]  wr_data_i
);

  mac_tok_t               tok_q;
  logic [RW-1:0]          rd_row;
  logic [16*LANES-1:0]    rd_data;
  logic signed [15:0]     wgt;
  logic                   p_vld_q, p_first_q, p_last_q;
  logic signed [31:0]     prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                   fin_q;
  res_tok_t               res_q;

  assign rd_row = RW'((32'(tok_i.wd) * WPP) + 32'(tok_i.grp));

  pcrq_ram #(
    .WIDTH (16 * LANES),
    .DEPTH (WPP * WPP)
  ) u_wbank (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_row_i),
    .wdata_i (wr_data_i),
    .raddr_i (rd_row),
    .rdata_o (rd_data)
  );

  assign wgt = $signed(rd_data[16*tok_q.lane[LW-1:0] +: 16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      p_vld_q   <= 1'b0;
      p_first_q <= 1'b0;
      p_last_q  <= 1'b0;
      fin_q     <= 1'b0;
      res_q     <= '0;
    end else begin
      tok_q     <= tok_i;
      p_vld_q   <= tok_q.vld;
      p_first_q <= tok_q.first;
      p_last_q  <= tok_q.last;
      fin_q     <= p_vld_q & p_last_q;
      // own sum takes the slot; traffic from the far side never lands here then
      if (fin_q) begin
        res_q <= '{vld: 1'b1, acc: acc_q};
      end else begin
        res_q <= res_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= tok_q.pix * wgt;
    if (p_vld_q) begin
      if (p_first_q) begin
        acc_q <= ACC_W'(prod_q);
      end else begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign tok_o = tok_q;
  assign res_o = res_q;

endmodule

### src/pcrq_requant.sv
// ----------------------------------------------------------------------------
// pcrq_requant
// Scales, shifts, biases and clamps each finished sum, then packs a word.
// ----------------------------------------------------------------------------
module pcrq_requant
  import pcrq_pkg::*;
#(
  parameter int unsigned CHANNELS = 512,
  parameter int unsigned LANES    = 32,
  localparam int unsigned WPP = CHANNELS / LANES,
  localparam int unsigned WW  = (WPP > 1) ? $clog2(WPP) : 1,
  localparam int unsigned LW  = $clog2(LANES),
  localparam int unsigned CW  = $clog2(CHANNELS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [6:0]    shift_i,
  input  res_tok_t      res_i,
  input  logic          prm_we_i,
  input  logic [CW-1:0] prm_waddr_i,
  input  logic [63:0]   prm_wdata_i,
  output out_item_t     result_o,
  output logic          result_valid_o
);

  logic [WW-1:0]  in_wd_q, pk_wd_q;
  logic [LW-1:0]  in_lane_q, pk_lane_q;
  logic [CW-1:0]  prm_raddr;
  logic [63:0]    prm_rdata;

  logic                    v0_q, v1_q, v2_q, v3_q, v4_q;
  logic signed [ACC_W-1:0] acc0_q;
  logic signed [56:0]      p0_q;
  logic signed [55:0]      p1_q;
  logic signed [71:0]      prod_q;
  logic [31:0]             bias1_q, bias2_q, bias3_q;
  logic [31:0]             low_q;
  logic [14:0]             val_q;
  logic [6:0]              sh;
  logic signed [71:0]      shifted;
  logic [31:0]             sum;
  logic [14:0]             clamp;
  logic [14:0]             buf_q [LANES];
  logic [511:0]            flat;
  out_item_t               res_d, result_q;
  logic                    result_valid_q;

  assign prm_raddr = CW'(32'(in_wd_q) * LANES + 32'(in_lane_q));

  pcrq_ram #(
    .WIDTH (64),
    .DEPTH (CHANNELS)
  ) u_prm (
    .clk_i   (clk_i),
    .we_i    (prm_we_i),
    .waddr_i (prm_waddr_i),
    .wdata_i (prm_wdata_i),
    .raddr_i (prm_raddr),
    .rdata_o (prm_rdata)
  );

  assign sh      = (shift_i > 7'(SHIFT_MAX)) ? 7'(SHIFT_MAX) : shift_i;
  assign shifted = prod_q >>> sh;
  assign sum     = low_q + bias3_q;

  always_comb begin
    if (sum[31]) begin
      clamp = '0;
    end else if (sum > 32'(OUT_MAX)) begin
      clamp = 15'(OUT_MAX);
    end else begin
      clamp = sum[14:0];
    end
  end

  always_comb begin
    flat = '0;
    for (int k = 0; k < LANES; k++) begin
      if (LW'(k) == pk_lane_q) begin
        flat[16*k +: 16] = {1'b0, val_q};
      end else begin
        flat[16*k +: 16] = {1'b0, buf_q[k]};
      end
    end
    res_d.word_number = 4'(pk_wd_q);
    res_d.out_0_3     = flat[0   +: 63];
    res_d.out_4_7     = flat[64  +: 63];
    res_d.out_8_11    = flat[128 +: 63];
    res_d.out_12_15   = flat[192 +: 63];
    res_d.out_16_19   = flat[256 +: 63];
    res_d.out_20_23   = flat[320 +: 63];
    res_d.out_24_27   = flat[384 +: 63];
    res_d.out_28_31   = flat[448 +: 63];
    res_d.last_word   = (pk_wd_q == WW'(WPP - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_wd_q        <= '0;
      in_lane_q      <= '0;
      pk_wd_q        <= '0;
      pk_lane_q      <= '0;
      v0_q           <= 1'b0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      v3_q           <= 1'b0;
      v4_q           <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      v0_q <= res_i.vld;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (res_i.vld) begin
        if (in_lane_q == LW'(LANES - 1)) begin
          in_lane_q <= '0;
          in_wd_q   <= (in_wd_q == WW'(WPP - 1)) ? '0 : in_wd_q + 1'b1;
        end else begin
          in_lane_q <= in_lane_q + 1'b1;
        end
      end
      result_valid_q <= v4_q && (pk_lane_q == LW'(LANES - 1));
      if (v4_q) begin
        if (pk_lane_q == LW'(LANES - 1)) begin
          pk_lane_q <= '0;
          pk_wd_q   <= (pk_wd_q == WW'(WPP - 1)) ? '0 : pk_wd_q + 1'b1;
        end else begin
          pk_lane_q <= pk_lane_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc0_q  <= res_i.acc;
    // 48x32 product split into two narrow partial products
    p0_q    <= $signed({1'b0, acc0_q[23:0]}) * $signed(prm_rdata[63:32]);
    p1_q    <= $signed(acc0_q[47:24]) * $signed(prm_rdata[63:32]);
    bias1_q <= prm_rdata[31:0];
    prod_q  <= $signed({p1_q[47:0], 24'b0}) + $signed({{15{p0_q[56]}}, p0_q});
    bias2_q <= bias1_q;
    low_q   <= shifted[31:0];
    bias3_q <= bias2_q;
    val_q   <= clamp;
    if (v4_q) begin
      buf_q[pk_lane_q] <= val_q;
      if (pk_lane_q == LW'(LANES - 1)) begin
        result_q <= res_d;
      end
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

endmodule

### src/pointwise_conv_requant_unit.sv
// ----------------------------------------------------------------------------
// pointwise_conv_requant_unit
// 1x1 convolution over a chain of mac cells with per-channel requantization.
// ----------------------------------------------------------------------------
// weight, parameter and partial pixel transactions leave busy low.
// the last word of a pixel starts CHANNELS/LANES_PER_WORD output words
// (one mac per cell per cycle), and busy stays high until the last word
// is out.
// reset clears control state only; stores hold garbage until written.
// results come as one-cycle strobes and the receiver cannot stall them.
module pointwise_conv_requant_unit
  import pcrq_pkg::*;
#(
  parameter int unsigned CHANNELS       = 512,
  parameter int unsigned LANES_PER_WORD = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item_i,
  output out_item_t   result_o,
  output logic        result_valid_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned LANES = LANES_PER_WORD;
  localparam int unsigned WPP   = CHANNELS / LANES;
  localparam int unsigned WW    = (WPP > 1) ? $clog2(WPP) : 1;
  localparam int unsigned LW    = $clog2(LANES);
  localparam int unsigned CW    = $clog2(CHANNELS);
  localparam int unsigned RW    = (WPP * WPP > 1) ? $clog2(WPP * WPP) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN
  } state_e;

  state_e        state_q;
  logic [WW-1:0] wcnt_q, wd_q, grp_q;
  logic [LW-1:0] lane_q;
  logic [6:0]    shift_q;
  mac_tok_t      a_q;
  logic          accept;
  op_e           op;
  logic [511:0]  lane_flat;
  logic [16*LANES-1:0] pix_rdata;
  logic          pix_we;

  logic          wt_we;
  logic [31:0]   oc;
  logic [31:0]   wt_cell;
  logic [RW-1:0] wt_row;
  logic          prm_we;

  mac_tok_t      tok [LANES+1];
  res_tok_t      res [LANES+1];

  assign accept    = start && (state_q == ST_IDLE);
  assign busy      = (state_q != ST_IDLE);
  assign op        = op_e'(item_i.operation);
  assign lane_flat = {item_i.lanes_28_31, item_i.lanes_24_27, item_i.lanes_20_23,
                      item_i.lanes_16_19, item_i.lanes_12_15, item_i.lanes_8_11,
                      item_i.lanes_4_7, item_i.lanes_0_3};

  assign pready = 1'b1;
  assign prdata = {25'b0, shift_q};

  // weight row mapping: cell owns channels with the same lane, row by word and group
  assign oc      = 32'(item_i.target_index) / WPP;
  assign wt_cell = oc % LANES;
  assign wt_row  = RW'((oc / LANES) * WPP + (32'(item_i.target_index) % WPP));
  assign wt_we   = accept && (op == OP_WEIGHT) &&
                   (32'(item_i.target_index) < CHANNELS * WPP);
  assign prm_we  = accept && (op == OP_PARAM) &&
                   (32'(item_i.target_index) < CHANNELS);
  assign pix_we  = accept && (op == OP_PIXEL);

  pcrq_ram #(
    .WIDTH (16 * LANES),
    .DEPTH (WPP)
  ) u_pix (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (wcnt_q),
    .wdata_i (lane_flat[16*LANES-1:0]),
    .raddr_i (grp_q),
    .rdata_o (pix_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wcnt_q  <= '0;
      wd_q    <= '0;
      grp_q   <= '0;
      lane_q  <= '0;
      shift_q <= '0;
      a_q     <= '0;
    end else begin
      if (psel && penable && pwrite && pready && (reg_e'(paddr[2]) == REG_SHIFT)) begin
        shift_q <= pwdata[6:0];
      end
      a_q.vld <= (state_q == ST_FEED);
      unique case (state_q)
        ST_IDLE: begin
          if (pix_we) begin
            if (wcnt_q == WW'(WPP - 1)) begin
              wcnt_q  <= '0;
              wd_q    <= '0;
              grp_q   <= '0;
              lane_q  <= '0;
              state_q <= ST_FEED;
            end else begin
              wcnt_q <= wcnt_q + 1'b1;
            end
          end
        end
        ST_FEED: begin
          a_q.first <= (grp_q == '0) && (lane_q == '0);
          a_q.last  <= (grp_q == WW'(WPP - 1)) && (lane_q == LW'(LANES - 1));
          a_q.wd    <= 8'(wd_q);
          a_q.grp   <= 8'(grp_q);
          a_q.lane  <= 5'(lane_q);
          if (lane_q == LW'(LANES - 1)) begin
            lane_q <= '0;
            if (grp_q == WW'(WPP - 1)) begin
              grp_q <= '0;
              if (wd_q == WW'(WPP - 1)) begin
                wd_q    <= '0;
                state_q <= ST_DRAIN;
              end else begin
                wd_q <= wd_q + 1'b1;
              end
            end else begin
              grp_q <= grp_q + 1'b1;
            end
          end else begin
            lane_q <= lane_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (result_valid_o && result_o.last_word) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    tok[0]     = a_q;
    tok[0].pix = $signed(pix_rdata[16*a_q.lane[LW-1:0] +: 16]);
  end

  assign res[LANES] = '0;

  for (genvar k = 0; k < LANES; k++) begin : g_cell
    pcrq_mac_cell #(
      .LANES (LANES),
      .WPP   (WPP)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[k]),
      .tok_o     (tok[k+1]),
      .res_i     (res[k+1]),
      .res_o     (res[k]),
      .wr_en_i   (wt_we && (wt_cell == k)),
      .wr_row_i  (wt_row),
      .wr_data_i (lane_flat[16*LANES-1:0])
    );
  end

  pcrq_requant #(
    .CHANNELS (CHANNELS),
    .LANES    (LANES)
  ) u_rq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .shift_i        (shift_q),
    .res_i          (res[0]),
    .prm_we_i       (prm_we),
    .prm_waddr_i    (item_i.target_index[CW-1:0]),
    .prm_wdata_i    ({item_i.channel_multiplier, item_i.channel_bias}),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

`ifndef SYNTH
  a_result_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  a_sum_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res[0].vld |-> busy)
    else $error("finished sum leaves chain while idle");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_word) |=> !busy)
    else $error("still busy after last word");

  a_no_feed_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FEED) |=> !a_q.vld)
    else $error("token issued outside feed");
`endif

endmodule

### tb/pointwise_conv_requant_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointwise_conv_requant_unit_checker
// Snoops the command, result and register ports, predicts each output pixel
// and compares every result word field by field against the oldest pending one.
// ----------------------------------------------------------------------------
module pointwise_conv_requant_unit_checker
  import pcrq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  in_item_t    item_i,
  input  out_item_t   result_i,
  input  logic        result_valid_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          words_pending_o
);

  localparam int unsigned NCH    = 512;
  localparam int unsigned NLANE  = 32;
  localparam int unsigned NWORDS = NCH / NLANE;

  logic signed [15:0] weights [NCH*NCH];
  logic signed [31:0] multipliers [NCH];
  logic signed [31:0] biases [NCH];
  logic signed [15:0] pixel [NCH];
  logic [3:0]         word_cnt;
  logic [6:0]         shift_amt;
  out_item_t          expected_words [$];

  assign words_pending_o = expected_words.size();

  function automatic logic [15:0] requant_channel(input int unsigned oc);
    longint             acc;
    logic signed [71:0] prod;
    logic signed [71:0] shifted;
    logic [31:0]        sum;
    int unsigned        sh;
    acc = 0;
    for (int unsigned ic = 0; ic < NCH; ic++) begin
      acc += longint'(pixel[ic]) * longint'(weights[oc*NCH + ic]);
    end
    // 72-bit product, wraps like the datapath
    prod = 72'(signed'(acc)) * 72'(signed'(multipliers[oc]));
    sh = (shift_amt > SHIFT_MAX) ? SHIFT_MAX : shift_amt;
    shifted = prod >>> sh;
    sum = shifted[31:0] + biases[oc];
    if ($signed(sum) < 0) return 16'd0;
    if ($signed(sum) > $signed(32'(OUT_MAX))) return 16'(OUT_MAX);
    return sum[15:0];
  endfunction

  task automatic emit_pixel();
    out_item_t   w;
    logic [511:0] packed_lanes;
    for (int unsigned wd = 0; wd < NWORDS; wd++) begin
      for (int unsigned k = 0; k < NLANE; k++) begin
        packed_lanes[16*k +: 16] = requant_channel(wd*NLANE + k);
      end
      w.word_number = 4'(wd);
      w.out_0_3     = packed_lanes[0   +: 63];
      w.out_4_7     = packed_lanes[64  +: 63];
      w.out_8_11    = packed_lanes[128 +: 63];
      w.out_12_15   = packed_lanes[192 +: 63];
      w.out_16_19   = packed_lanes[256 +: 63];
      w.out_20_23   = packed_lanes[320 +: 63];
      w.out_24_27   = packed_lanes[384 +: 63];
      w.out_28_31   = packed_lanes[448 +: 63];
      w.last_word   = (wd == NWORDS - 1);
      expected_words.push_back(w);
    end
  endtask

  task automatic absorb_command(input in_item_t it);
    logic [511:0] lanes;
    int unsigned  idx;
    lanes = {it.lanes_28_31, it.lanes_24_27, it.lanes_20_23, it.lanes_16_19,
             it.lanes_12_15, it.lanes_8_11, it.lanes_4_7, it.lanes_0_3};
    idx = it.target_index;
    case (op_e'(it.operation))
      OP_WEIGHT: begin
        if (idx < NCH * NWORDS) begin
          for (int unsigned k = 0; k < NLANE; k++) begin
            weights[(idx / NWORDS) * NCH + (idx % NWORDS) * NLANE + k] = lanes[16*k +: 16];
          end
        end
      end
      OP_PARAM: begin
        if (idx < NCH) begin
          multipliers[idx] = it.channel_multiplier;
          biases[idx]      = it.channel_bias;
        end
      end
      OP_PIXEL: begin
        for (int unsigned k = 0; k < NLANE; k++) begin
          pixel[word_cnt * NLANE + k] = lanes[16*k +: 16];
        end
        if (word_cnt == NWORDS - 1) begin
          word_cnt = 0;
          emit_pixel();
        end else begin
          word_cnt = word_cnt + 1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_word(input out_item_t act);
    out_item_t    exp;
    logic [508:0] e;
    logic [508:0] a;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected result transaction %h", $time, act);
      fail_count_o++;
      return;
    end
    exp = expected_words.pop_front();
    e = exp;
    a = act;
    if (exp.word_number != act.word_number) begin
      $display("%0t: word_number expected %0d actual %0d", $time,
               exp.word_number, act.word_number);
      fail_count_o++;
    end
    for (int j = 0; j < 8; j++) begin
      if (e[504-63*j -: 63] != a[504-63*j -: 63]) begin
        $display("%0t: word %0d lanes %0d..%0d expected %h actual %h", $time,
                 exp.word_number, 4*j, 4*j+3, e[504-63*j -: 63], a[504-63*j -: 63]);
        fail_count_o++;
      end
    end
    if (exp.last_word != act.last_word) begin
      $display("%0t: last_word expected %0b actual %0b", $time,
               exp.last_word, act.last_word);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    word_cnt     = 0;
    shift_amt    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_cnt  = 0;
      shift_amt = 0;
    end else begin
      if (result_valid_i) check_word(result_i);
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == 3'(4*REG_SHIFT)) begin
        shift_amt = pwdata_i[6:0];
      end
      if (start_i && !busy_i) absorb_command(item_i);
    end
  end

endmodule

### tb/pointwise_conv_requant_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointwise_conv_requant_unit_tb
// Fills every weight and channel parameter, then drives directed extremes and
// a random mix of loads, pixel words and ignored commands over several shifts.
// ----------------------------------------------------------------------------
module pointwise_conv_requant_unit_tb;
  import pcrq_pkg::*;

  localparam int LIMIT = 1500000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_item_t    item;
  out_item_t   result;
  logic        result_valid;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          words_pending;
  int          cycles;
  bit          idle_on;

  pointwise_conv_requant_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item),
    .result_o(result), .result_valid_o(result_valid), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pointwise_conv_requant_unit_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .item_i(item),
    .result_i(result), .result_valid_i(result_valid), .psel_i(psel),
    .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata),
    .pready_i(pready), .fail_count_o(fail_count), .words_pending_o(words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("pointwise_conv_requant_unit_tb failed");
      $finish;
    end
  end

  function automatic logic [63:0] lane_group(input int mode);
    case (mode)
      1: return {4{16'h8000}};
      2: return {4{16'h7fff}};
      3: return {4{16'h0000}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t make_item(input op_e op, input int unsigned idx, input int mode);
    in_item_t it;
    it.operation    = op;
    it.target_index = 13'(idx);
    it.lanes_0_3    = lane_group(mode);
    it.lanes_4_7    = lane_group(mode);
    it.lanes_8_11   = lane_group(mode);
    it.lanes_12_15  = lane_group(mode);
    it.lanes_16_19  = lane_group(mode);
    it.lanes_20_23  = lane_group(mode);
    it.lanes_24_27  = lane_group(mode);
    it.lanes_28_31  = lane_group(mode);
    it.channel_multiplier = $urandom;
    // mostly moderate biases so outputs land inside the clamp window
    it.channel_bias = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40000) - 20000;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_shift(input logic [31:0] value);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4*REG_SHIFT);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    in_item_t it;
    int       r;
    int       mode;
    for (int i = 0; i < n; i++) begin
      r    = $urandom_range(0, 99);
      mode = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
      if (r < 45) begin
        it = make_item(OP_PIXEL, $urandom_range(0, 8191), mode);
      end else if (r < 70) begin
        it = make_item(OP_WEIGHT, $urandom_range(0, 8191), mode);
      end else if (r < 92) begin
        it = make_item(OP_PARAM, ($urandom_range(0, 9) == 0) ?
                       $urandom_range(512, 8191) : $urandom_range(0, 511), mode);
      end else begin
        it = make_item(OP_NONE, $urandom_range(0, 8191), mode);
      end
      send(it);
    end
  endtask

  initial begin
    in_item_t it;
    cycles  = 0;
    idle_on = 1'b1;
    rst_ni  = 1'b0;
    start   = 1'b0;
    item    = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_shift(32'd50);
    // every store entry gets written before any pixel reads it
    for (int t = 0; t < 8192; t++) send(make_item(OP_WEIGHT, t, 0));
    for (int c = 0; c < 512; c++) send(make_item(OP_PARAM, c, 0));

    // directed: extreme weights and parameters, ignored commands, extreme pixel
    send(make_item(OP_WEIGHT, 0, 1));
    send(make_item(OP_WEIGHT, 17, 2));
    it = make_item(OP_PARAM, 0, 0);
    it.channel_multiplier = 32'sh8000_0000;
    it.channel_bias       = 32'sh7fff_ffff;
    send(it);
    it = make_item(OP_PARAM, 1, 0);
    it.channel_multiplier = 32'sh7fff_ffff;
    it.channel_bias       = 32'sh8000_0000;
    send(it);
    send(make_item(OP_NONE, 8191, 2));
    send(make_item(OP_PARAM, 8191, 1));
    send(make_item(OP_PARAM, 512, 2));
    for (int w = 0; w < 16; w++) send(make_item(OP_PIXEL, 0, (w % 2) ? 2 : 1));

    write_shift(32'd0);
    random_phase(60);
    write_shift(32'd71);
    random_phase(60);
    idle_on = 1'b0;
    write_shift(32'd127);
    random_phase(60);
    write_shift(32'd45);
    random_phase(100);
    idle_on = 1'b1;
    // sender holds off until all pending words are out
    drain();
    random_phase(80);
    write_shift(32'd56);
    random_phase(100);

    drain();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("pointwise_conv_requant_unit_tb passed");
    end else begin
      $display("pointwise_conv_requant_unit_tb failed");
    end
    $finish;
  end

endmodule
